@@ sv/bsm_pkg.sv @@
// Shared constants, types and Booth pair codes for the signed Booth multiplier.
`default_nettype none

package bsm_pkg;

    // Operand width; bit OPERAND_WIDTH-1 is the sign bit
    localparam int OPERAND_WIDTH   = 16;
    localparam int PRODUCT_WIDTH   = 32;

    // Booth steps done between two pipeline registers
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = (OPERAND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Scanned bits, padded up to a whole number of stages
    localparam int SCAN_WIDTH      = NUM_STAGES * STEPS_PER_STAGE;

    // Booth pair {current bit, lower bit}
    localparam logic [1:0] PAIR_ADD = 2'b01;
    localparam logic [1:0] PAIR_SUB = 2'b10;

    typedef struct packed {
        logic [SCAN_WIDTH-1:0]    scan;
        logic                     prev;
        logic [PRODUCT_WIDTH-1:0] cand;
        logic [PRODUCT_WIDTH-1:0] acc;
    } bsm_data_t;

endpackage

`default_nettype wire

@@ sv/bsm_stage.sv @@
// One pipeline stage: STEPS_PER_STAGE Booth steps and the stage register with its valid bit.
`default_nettype none

module bsm_stage
    import bsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire bsm_data_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output bsm_data_t      out_data
);

    logic      valid_reg;
    bsm_data_t data_reg;
    bsm_data_t data_next;

    // Stage takes a transaction when empty or when its content moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [1:0] pair;
        data_next = in_data;
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            pair = {data_next.scan[0], data_next.prev};
            unique case (pair)
                PAIR_ADD: data_next.acc = data_next.acc + data_next.cand;
                PAIR_SUB: data_next.acc = data_next.acc - data_next.cand;
                default:  data_next.acc = data_next.acc;
            endcase
            data_next.prev = data_next.scan[0];
            data_next.scan = data_next.scan >> 1;
            data_next.cand = data_next.cand << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/booth_signed_multiplier_core.sv @@
// Top level of the pipelined radix-2 Booth signed multiplier.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | in_valid / in_ready  | multiplier, multiplicand (signed)
//  output   | out_valid / out_ready| product (signed, 32 bits)
//
// Each transaction passes through the chain of stage registers; one enters per cycle while in_ready is high.
// Each stage register does STEPS_PER_STAGE Booth add/subtract steps on the 32-bit sum.
// Reset clears the stage valid bits only; the pipeline is empty afterwards.
// A stall at the output holds each full stage with only full stages ahead; the rest move up and fill empty stages.
`default_nettype none

module booth_signed_multiplier_core
    import bsm_pkg::*;
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [OPERAND_WIDTH-1:0] multiplier,
    input  wire logic signed [OPERAND_WIDTH-1:0] multiplicand,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [PRODUCT_WIDTH-1:0]      product
);

    logic      stage_valid [NUM_STAGES+1];
    logic      stage_ready [NUM_STAGES+1];
    bsm_data_t stage_data  [NUM_STAGES+1];

    // Sign-extend the scanned operand so padded steps see pairs 00 or 11
    assign stage_data[0] = '{
        scan: SCAN_WIDTH'(multiplier),
        prev: 1'b0,
        cand: PRODUCT_WIDTH'(multiplicand),
        acc:  '0
    };

    assign stage_valid[0] = in_valid;
    assign in_ready       = stage_ready[0];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        bsm_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[s]),
            .in_ready  (stage_ready[s]),
            .in_data   (stage_data[s]),
            .out_valid (stage_valid[s+1]),
            .out_ready (stage_ready[s+1]),
            .out_data  (stage_data[s+1])
        );
    end

    assign stage_ready[NUM_STAGES] = out_ready;
    assign out_valid               = stage_valid[NUM_STAGES];
    assign product                 = stage_data[NUM_STAGES].acc;

endmodule

`default_nettype wire

@@ sv/bsm_checker.sv @@
// Port-level checks for the Booth multiplier and the bind that attaches them.
`default_nettype none

module bsm_checker
    import bsm_pkg::*;
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic signed [OPERAND_WIDTH-1:0] multiplier,
    input wire logic signed [OPERAND_WIDTH-1:0] multiplicand,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic signed [PRODUCT_WIDTH-1:0] product
);

    // Hold a waiting input transaction
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=>
            in_valid && $stable(multiplier) && $stable(multiplicand))
        else $error("input transaction changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(product))
        else $error("result changed while stalled");

    // An empty output stage means the whole pipeline can advance
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // Ready at the output propagates to the input in the same cycle
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind booth_signed_multiplier_core bsm_checker u_bsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .multiplier   (multiplier),
    .multiplicand (multiplicand),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .product      (product)
);

`default_nettype wire

@@ bench/booth_signed_multiplier_core_tb.sv @@
// Self-checking testbench for the pipelined signed Booth multiplier core.
`default_nettype none

module booth_signed_multiplier_core_tb;
    import bsm_pkg::*;

    typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
    typedef logic signed [PRODUCT_WIDTH-1:0] product_t;

    localparam operand_t OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
    localparam operand_t OP_MAX = ~OP_MIN;
    localparam int       DRAIN_CYCLES = NUM_STAGES * 4;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    operand_t multiplier = '0;
    operand_t multiplicand = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    product_t product;

    // Idling controls for the sending and receiving sides
    bit       gaps_on = 1'b0;
    bit       stalls_on = 1'b0;
    int       stall_left = 0;
    int       mismatch_count = 0;
    product_t expected_products[$];
    product_t want;

    booth_signed_multiplier_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .multiplier   (multiplier),
        .multiplicand (multiplicand),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .product      (product)
    );

    always #1 clk = ~clk;

    // Radix-2 Booth recoding over the operand width, sum kept at product width
    function automatic product_t booth_product(operand_t mr, operand_t md);
        logic [PRODUCT_WIDTH-1:0] sum;
        logic [PRODUCT_WIDTH-1:0] addend;
        logic                     lower;
        sum    = '0;
        addend = PRODUCT_WIDTH'(md);
        lower  = 1'b0;
        for (int k = 0; k < OPERAND_WIDTH; k++)
        begin
            case ({mr[k], lower})
                PAIR_ADD: sum = sum + (addend << k);
                PAIR_SUB: sum = sum - (addend << k);
                default:  ;
            endcase
            lower = mr[k];
        end
        return product_t'(sum);
    endfunction

    // Operand biased toward extremes and long bit runs
    function automatic operand_t pick_operand();
        operand_t v;
        case ($urandom_range(0, 9))
            0:       v = OP_MIN;
            1:       v = OP_MAX;
            2:       v = operand_t'($urandom_range(0, 2)) - operand_t'(1);
            3:       v = {(OPERAND_WIDTH/2){2'b01}} ^ operand_t'($urandom & $urandom & $urandom);
            4:       v = operand_t'(1) << $urandom_range(0, OPERAND_WIDTH-1);
            5:       v = ~(operand_t'(1) << $urandom_range(0, OPERAND_WIDTH-1));
            default: v = operand_t'($urandom);
        endcase
        return v;
    endfunction

    // Receiver: starts random stall bursts while stalls_on is set
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Check the output transaction first, then record the input transaction
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_products.size() == 0)
            begin
                $error("product: no transaction pending, actual %0d", product);
                mismatch_count++;
            end
            else
            begin
                want = expected_products.pop_front();
                if (product !== want)
                begin
                    $error("product: expected %0d, actual %0d", want, product);
                    mismatch_count++;
                end
            end
        end
        if (in_valid && in_ready)
            expected_products.push_back(booth_product(multiplier, multiplicand));
    end

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_operands(operand_t mr, operand_t md);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        multiplier   <= mr;
        multiplicand <= md;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_empty();
        in_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corner_operands();
        operand_t corners[5];
        corners = '{OP_MIN, operand_t'(-1), operand_t'(0), operand_t'(1), OP_MAX};
        foreach (corners[i])
            foreach (corners[j])
                send_operands(corners[i], corners[j]);
    endtask

    task automatic test_random_operands(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_operands(operand_t'($urandom), operand_t'($urandom));
            else
                send_operands(pick_operand(), pick_operand());
            // Switch idling off now and then for a stretch
            if (n % 100 == 0)
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
        end
    endtask

    task automatic test_bit_patterns(int count);
        for (int n = 0; n < count; n++)
            send_operands(pick_operand(), pick_operand());
    endtask

    task automatic test_pause_until_empty();
        for (int n = 0; n < 40; n++)
            send_operands(pick_operand(), operand_t'($urandom));
        wait_for_empty();
        @(negedge clk);
        for (int n = 0; n < 40; n++)
            send_operands(operand_t'($urandom), pick_operand());
    endtask

    task automatic test_full_rate(int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int n = 0; n < count; n++)
            send_operands(operand_t'($urandom), pick_operand());
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_operands();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_random_operands(700);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_bit_patterns(250);
        test_pause_until_empty();
        test_full_rate(300);

        wait_for_empty();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("booth_signed_multiplier_core verification clean");
        else
            $display("booth_signed_multiplier_core verification failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("booth_signed_multiplier_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
